/* rtl/ofq_pkg.sv */
// ----------------------------------------------------------------------------
// ofq_pkg
// Shared types, constants and helpers of the offset u16 quantize/dequantize
// pipeline.
// ----------------------------------------------------------------------------
package ofq_pkg;

	localparam int QUO_W          = 26;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

	localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
	localparam logic [15:0] CODE_OFFSET = 16'h8000;
	localparam logic [15:0] CODE_MAX    = 16'hFFFF;
	localparam logic [31:0] F32_QNAN    = 32'h0040_0000;
	localparam logic [31:0] F32_DEF_NAN = 32'hFFC0_0000;

	typedef enum logic [1:0] {
		FN_Q32 = 2'd0,
		FN_D32 = 2'd1,
		FN_Q16 = 2'd2,
		FN_D16 = 2'd3
	} func_t;

	// quotient class, decided up front
	typedef enum logic [1:0] {
		QC_DIV  = 2'd0,
		QC_ZERO = 2'd1,
		QC_MAX  = 2'd2
	} qcls_t;

	typedef struct packed {
		func_t              func;
		qcls_t              qcls;
		logic signed [9:0]  qexp;
		logic [24:0]        rem;
		logic [23:0]        dvs;
		logic [25:0]        quo;
		logic [31:0]        dq;
	} pipe_t;

	typedef struct packed {
		pipe_t       p;
		logic [39:0] prod;
		logic [7:0]  ses;
		logic        ssign;
		logic        dq_sp;
	} front_t;

	function automatic logic [4:0] msb24(input logic [23:0] x);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 24; i++) begin
			if (x[i]) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [5:0] msb40(input logic [39:0] x);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 40; i++) begin
			if (x[i]) r = 6'(i);
		end
		return r;
	endfunction

endpackage

/* rtl/ofq_front.sv */
// ----------------------------------------------------------------------------
// ofq_front
// Unpacks and normalizes the operand and the scale, classifies the quotient
// and forms the dequantize product.
// ----------------------------------------------------------------------------
module ofq_front import ofq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  logic [1:0]  func,
	input  logic [31:0] value_bits,
	input  logic [31:0] scale_bits,
	output logic        v_s1,
	output front_t      d_s1
);

	logic              xs, xspec, xzero, xnan, xinf;
	logic signed [9:0] xexp_raw, xexp;
	logic [23:0]       xman_raw, xman;
	logic [4:0]        xlz, slz;
	logic              ss, sspec, szero, snan, sinf;
	logic [7:0]        se;
	logic [22:0]       sf;
	logic signed [9:0] sexp_raw, sexp;
	logic [23:0]       sman_raw, sman;
	logic [15:0]       uval;
	front_t            d;

	always_comb begin
		if (func[1] == 1'b0) begin
			xs       = value_bits[31];
			xspec    = value_bits[30:23] == 8'hFF;
			xzero    = value_bits[30:0] == 31'd0;
			xnan     = xspec && (value_bits[22:0] != 23'd0);
			xexp_raw = (value_bits[30:23] == 8'd0) ? -10'sd126
				: $signed({2'b00, value_bits[30:23]}) - 10'sd127;
			xman_raw = {value_bits[30:23] != 8'd0, value_bits[22:0]};
		end else begin
			xs       = value_bits[15];
			xspec    = value_bits[14:10] == 5'h1F;
			xzero    = value_bits[14:0] == 15'd0;
			xnan     = xspec && (value_bits[9:0] != 10'd0);
			xexp_raw = (value_bits[14:10] == 5'd0) ? -10'sd14
				: $signed({5'b00000, value_bits[14:10]}) - 10'sd15;
			xman_raw = {value_bits[14:10] != 5'd0, value_bits[9:0], 13'd0};
		end
		xinf = xspec && !xnan;
		xlz  = 5'd23 - msb24(xman_raw);
		xman = xman_raw << xlz;
		xexp = xexp_raw - $signed({5'b00000, xlz});

		ss       = scale_bits[31];
		se       = scale_bits[30:23];
		sf       = scale_bits[22:0];
		sspec    = se == 8'hFF;
		szero    = scale_bits[30:0] == 31'd0;
		snan     = sspec && (sf != 23'd0);
		sinf     = sspec && !snan;
		sexp_raw = (se == 8'd0) ? -10'sd126 : $signed({2'b00, se}) - 10'sd127;
		sman_raw = {se != 8'd0, sf};
		slz      = 5'd23 - msb24(sman_raw);
		sman     = sman_raw << slz;
		sexp     = sexp_raw - $signed({5'b00000, slz});

		d        = '0;
		d.p.func = func_t'(func);
		d.p.qexp = xexp - sexp;
		d.p.rem  = {1'b0, xman};
		d.p.dvs  = sman;
		d.p.quo  = '0;

		// negative, zero, nan and tiny quotients all end at the bottom code
		if (xnan || snan || xzero) begin
			d.p.qcls = QC_ZERO;
		end else if (xinf) begin
			d.p.qcls = (!sinf && !(xs ^ ss)) ? QC_MAX : QC_ZERO;
		end else if (szero) begin
			d.p.qcls = (xs ^ ss) ? QC_ZERO : QC_MAX;
		end else if (sinf || (xs ^ ss)) begin
			d.p.qcls = QC_ZERO;
		end else begin
			d.p.qcls = QC_DIV;
		end

		uval    = value_bits[15:0] ^ CODE_OFFSET;
		d.prod  = 40'(uval) * 40'(sman_raw);
		d.ses   = (se == 8'd0) ? 8'd1 : se;
		d.ssign = ss;
		d.dq_sp = 1'b1;
		if (snan) begin
			d.p.dq = scale_bits | F32_QNAN;
		end else if (sinf) begin
			d.p.dq = (uval == 16'd0) ? F32_DEF_NAN : {ss, 8'hFF, 23'd0};
		end else if (szero || uval == 16'd0) begin
			d.p.dq = {ss, 31'd0};
		end else begin
			d.p.dq  = '0;
			d.dq_sp = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d;
		end
	end

endmodule

/* rtl/ofq_mul_round.sv */
// ----------------------------------------------------------------------------
// ofq_mul_round
// Normalizes and rounds the exact code times scale product to single
// precision, including subnormal and overflow results.
// ----------------------------------------------------------------------------
module ofq_mul_round import ofq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   v_in,
	input  front_t d_in,
	output logic   v_s2,
	output pipe_t  d_s2
);

	logic signed [9:0] ka, kb, k, bexp;
	logic [39:0]       shl, shr;
	logic [4:0]        rsh;
	logic [23:0]       m24;
	logic              g, st;
	logic [24:0]       mr;
	logic [22:0]       mant;
	pipe_t             d;

	always_comb begin
		ka  = $signed({4'b0000, msb40(d_in.prod)}) - 10'sd23;
		kb  = 10'sd1 - $signed({2'b00, d_in.ses});
		k   = (ka > kb) ? ka : kb;
		rsh = k[4:0];
		shl = d_in.prod << (5'd0 - rsh);
		shr = d_in.prod >> rsh;
		if (k <= 10'sd0) begin
			m24 = shl[23:0];
			g   = 1'b0;
			st  = 1'b0;
		end else begin
			m24 = shr[23:0];
			g   = d_in.prod[{1'b0, rsh - 5'd1}];
			st  = (d_in.prod & ((40'd1 << (rsh - 5'd1)) - 40'd1)) != 40'd0;
		end
		mr   = {1'b0, m24} + {24'd0, g & (st | m24[0])};
		bexp = k + $signed({2'b00, d_in.ses});
		if (mr[24]) begin
			bexp = bexp + 10'sd1;
			mant = '0;
		end else if (mr[23]) begin
			mant = mr[22:0];
		end else begin
			bexp = '0;
			mant = mr[22:0];
		end

		d = d_in.p;
		if (!d_in.dq_sp) begin
			if (bexp >= 10'sd255) begin
				d.dq = {d_in.ssign, 8'hFF, 23'd0};
			end else begin
				d.dq = {d_in.ssign, bexp[7:0], mant};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= d;
		end
	end

endmodule

/* rtl/ofq_div_stage.sv */
// ----------------------------------------------------------------------------
// ofq_div_stage
// One stage of the restoring mantissa divider, retiring BITS_PER_STAGE (two) quotient bits.
// ----------------------------------------------------------------------------
module ofq_div_stage import ofq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_in,
	input  pipe_t d_in,
	output logic  v_q,
	output pipe_t d_q
);

	logic [24:0] r;
	logic [25:0] q;
	pipe_t       d;

	always_comb begin
		r = d_in.rem;
		q = d_in.quo;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			if (r >= {1'b0, d_in.dvs}) begin
				r = r - {1'b0, d_in.dvs};
				q = {q[24:0], 1'b1};
			end else begin
				q = {q[24:0], 1'b0};
			end
			// remainder stays below the divisor, so the shift cannot overflow
			r = {r[23:0], 1'b0};
		end
		d     = d_in;
		d.rem = r;
		d.quo = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d;
		end
	end

endmodule

/* rtl/ofq_quo_round.sv */
// ----------------------------------------------------------------------------
// ofq_quo_round
// Rounds the raw quotient to a 24-bit single-precision significand.
// ----------------------------------------------------------------------------
module ofq_quo_round import ofq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_in,
	input  pipe_t d_in,
	output logic  v_s16,
	output pipe_t d_s16
);

	logic [23:0]       m24;
	logic              g, st;
	logic signed [9:0] e;
	logic [24:0]       mr;
	pipe_t             d;

	always_comb begin
		if (d_in.quo[25]) begin
			m24 = d_in.quo[25:2];
			g   = d_in.quo[1];
			st  = d_in.quo[0] | (d_in.rem != 25'd0);
			e   = d_in.qexp;
		end else begin
			m24 = d_in.quo[24:1];
			g   = d_in.quo[0];
			st  = d_in.rem != 25'd0;
			e   = d_in.qexp - 10'sd1;
		end
		mr = {1'b0, m24} + {24'd0, g & (st | m24[0])};
		d  = d_in;
		// significand goes back in the low quotient bits
		if (mr[24]) begin
			d.quo  = {2'b00, 24'h80_0000};
			d.qexp = e + 10'sd1;
		end else begin
			d.quo  = {2'b00, mr[23:0]};
			d.qexp = e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else if (en) begin
			v_s16 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s16 <= d;
		end
	end

endmodule

/* rtl/ofq_out_stage.sv */
// ----------------------------------------------------------------------------
// ofq_out_stage
// Integer rounding and clamping of the quotient, single to half conversion,
// result select and the output register.
// ----------------------------------------------------------------------------
module ofq_out_stage import ofq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  pipe_t       d_in,
	output logic        v_s17,
	output logic [31:0] res_s17
);

	function automatic logic [15:0] f32_to_f16(input logic [31:0] b);
		logic              sg;
		logic [7:0]        e;
		logic [23:0]       m;
		logic signed [9:0] ee;
		logic [4:0]        sh;
		logic [15:0]       h;
		logic [23:0]       rm, tie;
		sg = b[31];
		e  = b[30:23];
		m  = {1'b0, b[22:0]};
		ee = $signed({2'b00, e}) - 10'sd112;
		sh = 5'd0;
		h  = '0;
		rm = '0;
		tie = '0;
		if (e == 8'hFF) begin
			return (m != 24'd0) ? {sg, 5'h1F, 1'b1, m[21:13]} : {sg, 15'h7C00};
		end
		if (ee >= 10'sd31) begin
			return {sg, 15'h7C00};
		end
		if (ee <= 10'sd0) begin
			if (ee < -10'sd10) begin
				return {sg, 15'd0};
			end
			m   = m | 24'h80_0000;
			sh  = 5'(10'sd14 - ee);
			h   = 16'(m >> sh);
			rm  = m & ((24'd1 << sh) - 24'd1);
			tie = 24'd1 << (sh - 5'd1);
		end else begin
			h   = {1'b0, ee[4:0], m[22:13]};
			rm  = {11'd0, m[12:0]};
			tie = 24'h00_1000;
		end
		if (rm > tie || (rm == tie && h[0])) begin
			h = h + 16'd1;
		end
		return {sg, h[14:0]};
	endfunction

	logic [4:0]  sh;
	logic [23:0] ival, hval;
	logic [16:0] sum;
	logic [15:0] qint;
	logic [31:0] res;

	always_comb begin
		sh   = 5'(10'sd23 - d_in.qexp);
		ival = d_in.quo[23:0] >> sh;
		hval = d_in.quo[23:0] >> (sh - 5'd1);
		sum  = {1'b0, ival[15:0]} + {16'd0, hval[0]};
		case (d_in.qcls)
			QC_MAX:  qint = CODE_MAX;
			QC_ZERO: qint = '0;
			QC_DIV: begin
				if (d_in.qexp >= 10'sd16) begin
					qint = CODE_MAX;
				end else if (d_in.qexp < -10'sd1) begin
					qint = '0;
				end else begin
					qint = sum[16] ? CODE_MAX : sum[15:0];
				end
			end
			default: qint = '0;
		endcase

		case (d_in.func)
			FN_D32:  res = d_in.dq;
			FN_D16:  res = {16'd0, f32_to_f16(d_in.dq)};
			default: res = {16'd0, qint ^ CODE_OFFSET};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
		end else if (en) begin
			v_s17 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s17 <= res;
		end
	end

endmodule

/* rtl/offset_u16_quantize_dequantize_top.sv */
// ----------------------------------------------------------------------------
// offset_u16_quantize_dequantize_top
// Converts between single or half precision values and offset 16-bit codes
// using the configured scale.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while in_stall is low. Each item
// passes the front, multiply-round, divider, quotient-round and output
// registers in order; the 13-stage restoring divider forms the quantize
// quotient two bits per stage, and dequantize items walk the same stages so
// results leave in order. When out_stall holds a waiting result the whole
// pipeline freezes, empty slots included, and in_stall rises until the
// result is taken. Write scale_bits only while no transaction is in flight.
module offset_u16_quantize_dequantize_top import ofq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] value_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] scale_bits
);

	logic        adv;
	logic [31:0] scale_q;
	logic        v_s1, v_s2, v_s16;
	front_t      d_s1;
	pipe_t       d_s2, d_s16;
	logic        v_div [DIV_STAGES+1];
	pipe_t       d_div [DIV_STAGES+1];

	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= scale_bits;
		end
	end

	ofq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.v_in       (in_valid),
		.func       (func),
		.value_bits (value_bits),
		.scale_bits (scale_q),
		.v_s1       (v_s1),
		.d_s1       (d_s1)
	);

	ofq_mul_round u_mul_round (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_s1),
		.d_in   (d_s1),
		.v_s2   (v_s2),
		.d_s2   (d_s2)
	);

	assign v_div[0] = v_s2;
	assign d_div[0] = d_s2;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		ofq_div_stage u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.v_in   (v_div[i]),
			.d_in   (d_div[i]),
			.v_q    (v_div[i+1]),
			.d_q    (d_div[i+1])
		);
	end

	ofq_quo_round u_quo_round (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_div[DIV_STAGES]),
		.d_in   (d_div[DIV_STAGES]),
		.v_s16  (v_s16),
		.d_s16  (d_s16)
	);

	ofq_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.v_in    (v_s16),
		.d_in    (d_s16),
		.v_s17   (out_valid),
		.res_s17 (result_bits)
	);

endmodule
